@@ src/msp_pkg.sv @@
// shared types and constants for the matrix saddle point finder
package msp_pkg;

  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int OUT_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

@@ src/msp_cmp.sv @@
// shared signed compare unit used for min, max and match checks
module msp_cmp (
  input  logic signed [msp_pkg::VALUE_W-1:0] a,
  input  logic signed [msp_pkg::VALUE_W-1:0] b,
  output msp_pkg::cmp_res_t                  res
);

  assign res.lt = (a < b);
  assign res.eq = (a == b);

endmodule

@@ src/msp_store.sv @@
// register file for per-row minimum or per-column maximum
module msp_store #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [msp_pkg::VALUE_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [msp_pkg::VALUE_W-1:0] rdata
);

  logic [msp_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = mem[raddr];

endmodule

@@ src/matrix_saddle_point_finder_top.sv @@
// top level of the matrix saddle point finder: sequencer, stores and output register
//
// Usage: matrix elements arrive one word at a time on in_valid/in_ready in
// row-major order. Register 0 (row_count) and register 1 (column_count) are
// written over cfg_valid/cfg_ready/cfg_index/cfg_data while the block is idle;
// a write restarts the matrix at row 0, column 0, and in_ready stays low while
// cfg_valid is high. Counts of 0 act as 1, and counts above MAX_ROWS/MAX_COLUMNS
// act as the maximum.
// Each element is accepted, then goes through a row-minimum update and a
// column-maximum update, both through one shared signed comparator. After the last element
// the same comparator scans every row/column pair, one pair per cycle unless
// a stall holds the scan, and then the final word is emitted.
// Results leave on out_valid/out_ready through an output register; one word
// per matching pair, the final one with last_result set, or a single word with
// found cleared when no pair matches. A stalled receiver holds the scan when a
// second match must be pushed while the output register is still full, and
// holds the final word until the output register drains.
// Reset (rst, synchronous) empties the output and sets both counts to 1.
module matrix_saddle_point_finder_top #(
  parameter int MAX_ROWS    = 8,
  parameter int MAX_COLUMNS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [msp_pkg::VALUE_W-1:0]   element_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [msp_pkg::VALUE_W-1:0]   saddle_value,
  output logic [msp_pkg::OUT_INDEX_W-1:0]      saddle_row,
  output logic [msp_pkg::OUT_INDEX_W-1:0]      saddle_column,
  output logic                                 found,
  output logic                                 last_result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [msp_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [msp_pkg::COUNT_W-1:0]          cfg_data
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W = msp_pkg::COUNT_W;
  localparam int VW    = msp_pkg::VALUE_W;
  localparam int OW    = msp_pkg::OUT_INDEX_W;
  localparam logic [CNT_W-1:0] ROW_LIMIT = CNT_W'(MAX_ROWS);
  localparam logic [CNT_W-1:0] COL_LIMIT = CNT_W'(MAX_COLUMNS);

  typedef enum logic [2:0] {
    IDLE,
    ROW_UPD,
    COL_UPD,
    SCAN,
    FLUSH
  } state_t;

  state_t state;

  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] column_count;
  logic [RW-1:0]    row_pos;
  logic [CW-1:0]    col_pos;
  logic [RW-1:0]    cur_r;
  logic [CW-1:0]    cur_c;
  logic [VW-1:0]    value;
  logic [RW-1:0]    scan_i;
  logic [CW-1:0]    scan_j;
  logic             pend_valid;
  logic [VW-1:0]    pend_value;
  logic [RW-1:0]    pend_row;
  logic [CW-1:0]    pend_col;

  logic [CNT_W-1:0] rows_eff;
  logic [CNT_W-1:0] cols_eff;
  logic             pos_ok;
  logic             out_free;
  logic             out_load;
  logic             stall;
  logic             last_j;
  logic             last_i;

  logic             row_we;
  logic             col_we;
  logic [RW-1:0]    row_raddr;
  logic [CW-1:0]    col_raddr;
  logic [VW-1:0]    row_rd;
  logic [VW-1:0]    col_rd;
  logic [VW-1:0]    cmp_a;
  logic [VW-1:0]    cmp_b;
  msp_pkg::cmp_res_t cmp;

  // effective counts
  always_comb begin
    priority if (row_count == '0) begin
      rows_eff = CNT_W'(1);
    end else if (row_count > ROW_LIMIT) begin
      rows_eff = ROW_LIMIT;
    end else begin
      rows_eff = row_count;
    end
    priority if (column_count == '0) begin
      cols_eff = CNT_W'(1);
    end else if (column_count > COL_LIMIT) begin
      cols_eff = COL_LIMIT;
    end else begin
      cols_eff = column_count;
    end
  end

  assign pos_ok   = (CNT_W'(row_pos) < rows_eff) && (CNT_W'(col_pos) < cols_eff);
  assign in_ready = (state == IDLE) && !cfg_valid;
  assign cfg_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;
  assign stall    = cmp.eq && pend_valid && !out_free;
  assign out_load = ((state == SCAN) && !stall && cmp.eq && pend_valid) ||
                    ((state == FLUSH) && out_free);
  assign last_j   = (CNT_W'(scan_j) + CNT_W'(1)) >= cols_eff;
  assign last_i   = (CNT_W'(scan_i) + CNT_W'(1)) >= rows_eff;

  // operand selection for the shared comparator
  always_comb begin
    row_raddr = (state == SCAN) ? scan_i : cur_r;
    col_raddr = (state == SCAN) ? scan_j : cur_c;
    unique case (state)
      ROW_UPD: begin
        cmp_a = value;
        cmp_b = row_rd;
      end
      COL_UPD: begin
        cmp_a = col_rd;
        cmp_b = value;
      end
      default: begin
        cmp_a = row_rd;
        cmp_b = col_rd;
      end
    endcase
    row_we = (state == ROW_UPD) && ((cur_c == '0) || cmp.lt);
    col_we = (state == COL_UPD) && ((cur_r == '0) || cmp.lt);
  end

  msp_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  msp_store #(
    .DEPTH (MAX_ROWS),
    .AW    (RW)
  ) u_row_store (
    .clk   (clk),
    .we    (row_we),
    .waddr (cur_r),
    .wdata (value),
    .raddr (row_raddr),
    .rdata (row_rd)
  );

  msp_store #(
    .DEPTH (MAX_COLUMNS),
    .AW    (CW)
  ) u_col_store (
    .clk   (clk),
    .we    (col_we),
    .waddr (cur_c),
    .wdata (value),
    .raddr (col_raddr),
    .rdata (col_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      row_count    <= CNT_W'(1);
      column_count <= CNT_W'(1);
      row_pos      <= '0;
      col_pos      <= '0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == msp_pkg::REG_ROW_COUNT) begin
              row_count <= cfg_data;
              row_pos   <= '0;
              col_pos   <= '0;
            end else if (cfg_index == msp_pkg::REG_COLUMN_COUNT) begin
              column_count <= cfg_data;
              row_pos      <= '0;
              col_pos      <= '0;
            end
          end else if (in_valid) begin
            value <= element_value;
            cur_r <= pos_ok ? row_pos : '0;
            cur_c <= pos_ok ? col_pos : '0;
            state <= ROW_UPD;
          end
        end
        ROW_UPD: begin
          state <= COL_UPD;
        end
        COL_UPD: begin
          if ((CNT_W'(cur_c) + CNT_W'(1)) < cols_eff) begin
            col_pos <= cur_c + CW'(1);
            row_pos <= cur_r;
            state   <= IDLE;
          end else begin
            col_pos <= '0;
            if ((CNT_W'(cur_r) + CNT_W'(1)) < rows_eff) begin
              row_pos <= cur_r + RW'(1);
              state   <= IDLE;
            end else begin
              row_pos    <= '0;
              scan_i     <= '0;
              scan_j     <= '0;
              pend_valid <= 1'b0;
              state      <= SCAN;
            end
          end
        end
        SCAN: begin
          if (!stall) begin
            if (cmp.eq) begin
              if (pend_valid) begin
                out_valid     <= 1'b1;
                saddle_value  <= pend_value;
                saddle_row    <= OW'(pend_row);
                saddle_column <= OW'(pend_col);
                found         <= 1'b1;
                last_result   <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_value <= row_rd;
              pend_row   <= scan_i;
              pend_col   <= scan_j;
            end
            if (!last_j) begin
              scan_j <= scan_j + CW'(1);
            end else begin
              scan_j <= '0;
              if (last_i) begin
                state <= FLUSH;
              end else begin
                scan_i <= scan_i + RW'(1);
              end
            end
          end
        end
        FLUSH: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            saddle_value  <= pend_valid ? pend_value : '0;
            saddle_row    <= pend_valid ? OW'(pend_row) : '0;
            saddle_column <= pend_valid ? OW'(pend_col) : '0;
            found         <= pend_valid;
            last_result   <= 1'b1;
            pend_valid    <= 1'b0;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_not_found_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> last_result && (saddle_value == '0))
    else $error("no-match word must be final and zero");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> (CNT_W'(row_pos) < rows_eff) && (CNT_W'(col_pos) < cols_eff))
    else $error("matrix position outside counts");

  a_stall_holds_scan: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN) && stall |=> (state == SCAN) && $stable(scan_i) && $stable(scan_j))
    else $error("scan advanced while a match was pending");

  a_flush_ends_matrix: assert property (@(posedge clk) disable iff (rst)
    (state == FLUSH) && out_free |=> out_valid && last_result && (state == IDLE))
    else $error("final word not issued");

endmodule

@@ sim/tb.sv @@
// testbench for the matrix saddle point finder: directed and random matrices checked by a predictor
`timescale 1ns / 100ps

module tb;

  localparam int VALUE_W     = msp_pkg::VALUE_W;
  localparam int COUNT_W     = msp_pkg::COUNT_W;
  localparam int CFG_INDEX_W = msp_pkg::CFG_INDEX_W;
  localparam int OUT_INDEX_W = msp_pkg::OUT_INDEX_W;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = msp_pkg::REG_ROW_COUNT;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = msp_pkg::REG_COLUMN_COUNT;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLUMNS = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int WORD_TARGET = 260;
  localparam int SETTLE_CYCLES = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH = 2'd3;

  typedef logic signed [VALUE_W-1:0] word_t;

  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam word_t WORD_MAX = 32'sh7fff_ffff;

  typedef enum int {FILL_WIDE, FILL_NARROW, FILL_FLAT, FILL_EDGE} fill_mode_t;

  typedef struct {
    word_t            value;
    logic [OUT_INDEX_W-1:0] row;
    logic [OUT_INDEX_W-1:0] column;
    logic             hit;
    logic             closes;
  } saddle_t;

  logic clk;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_ready;
  word_t element_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  word_t saddle_value;
  logic [OUT_INDEX_W-1:0] saddle_row;
  logic [OUT_INDEX_W-1:0] saddle_column;
  logic found;
  logic last_result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [COUNT_W-1:0] cfg_data = '0;

  matrix_saddle_point_finder_top #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLUMNS(MAX_COLUMNS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .element_value(element_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .saddle_value(saddle_value),
    .saddle_row(saddle_row),
    .saddle_column(saddle_column),
    .found(found),
    .last_result(last_result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  word_t element_queue[$];
  saddle_t pending_saddles[$];

  word_t row_floor[MAX_ROWS];
  word_t col_peak[MAX_COLUMNS];
  logic [COUNT_W-1:0] rows_setting;
  logic [COUNT_W-1:0] cols_setting;
  int at_row;
  int at_col;

  logic in_took = 1'b0;
  logic cfg_took = 1'b0;
  logic steady = 1'b0;
  int items_queued = 0;
  int items_taken = 0;
  int results_checked = 0;
  int matrices_done = 0;
  int cfg_writes = 0;
  int error_count = 0;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int used_count(input logic [COUNT_W-1:0] setting, input int limit);
    if (setting == 0) return 1;
    if (setting > limit) return limit;
    return setting;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic clear_predictor();
    for (int i = 0; i < MAX_ROWS; i++) row_floor[i] = '0;
    for (int j = 0; j < MAX_COLUMNS; j++) col_peak[j] = '0;
    rows_setting = 4'd1;
    cols_setting = 4'd1;
    at_row = 0;
    at_col = 0;
  endtask

  task automatic set_register(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [COUNT_W-1:0] data);
    if (idx == REG_ROW_COUNT) begin
      rows_setting = data;
      at_row = 0;
      at_col = 0;
    end else if (idx == REG_COLUMN_COUNT) begin
      cols_setting = data;
      at_row = 0;
      at_col = 0;
    end
  endtask

  // running row minimum and column maximum, pair scan on the last word
  task automatic absorb_element(input word_t word);
    int nr;
    int nc;
    int r;
    int c;
    int hits;
    int k;
    saddle_t item;
    nr = used_count(rows_setting, MAX_ROWS);
    nc = used_count(cols_setting, MAX_COLUMNS);
    r = at_row;
    c = at_col;
    if (r >= nr || c >= nc) begin
      r = 0;
      c = 0;
    end
    if (c == 0 || word < row_floor[r]) row_floor[r] = word;
    if (r == 0 || word > col_peak[c]) col_peak[c] = word;
    if (c + 1 < nc) begin
      at_col = c + 1;
      at_row = r;
    end else begin
      at_col = 0;
      if (r + 1 < nr) begin
        at_row = r + 1;
      end else begin
        at_row = 0;
        matrices_done++;
        hits = 0;
        for (int i = 0; i < nr; i++)
          for (int j = 0; j < nc; j++)
            if (row_floor[i] == col_peak[j]) hits++;
        if (hits == 0) begin
          item.value = '0;
          item.row = '0;
          item.column = '0;
          item.hit = 1'b0;
          item.closes = 1'b1;
          pending_saddles.push_back(item);
        end else begin
          k = 0;
          for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
              if (row_floor[i] == col_peak[j]) begin
                k++;
                item.value = row_floor[i];
                item.row = OUT_INDEX_W'(i);
                item.column = OUT_INDEX_W'(j);
                item.hit = 1'b1;
                item.closes = (k == hits);
                pending_saddles.push_back(item);
              end
            end
          end
        end
      end
    end
  endtask

  task automatic check_saddle();
    saddle_t want;
    if (pending_saddles.size() == 0) begin
      report_mismatch($sformatf("unexpected word value %0d row %0d column %0d",
                                saddle_value, saddle_row, saddle_column));
    end else begin
      want = pending_saddles.pop_front();
      results_checked++;
      if (saddle_value !== want.value)
        report_mismatch($sformatf("saddle_value %0d, want %0d", saddle_value, want.value));
      if (saddle_row !== want.row)
        report_mismatch($sformatf("saddle_row %0d, want %0d", saddle_row, want.row));
      if (saddle_column !== want.column)
        report_mismatch($sformatf("saddle_column %0d, want %0d", saddle_column, want.column));
      if (found !== want.hit)
        report_mismatch($sformatf("found %0b, want %0b", found, want.hit));
      if (last_result !== want.closes)
        report_mismatch($sformatf("last_result %0b, want %0b", last_result, want.closes));
    end
  endtask

  // element driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (element_queue.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
        element_value <= element_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    out_ready <= !rst && (steady || $urandom_range(99) >= 25);
  end

  // monitor and predictor
  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
    cfg_took <= cfg_valid && cfg_ready;
    if (rst) begin
      clear_predictor();
    end else begin
      if (cfg_valid && cfg_ready) begin
        set_register(cfg_index, cfg_data);
        cfg_writes++;
      end
      if (in_valid && in_ready) begin
        absorb_element(element_value);
        items_taken++;
      end
      if (out_valid && out_ready) check_saddle();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic push_word(input word_t word);
    element_queue.push_back(word);
    items_queued++;
  endtask

  function automatic word_t pick_element(input fill_mode_t mode, input word_t fill);
    case (mode)
      FILL_WIDE:   return $urandom;
      FILL_NARROW: return int'($urandom_range(6)) - 3;
      FILL_FLAT:   return fill;
      default: begin
        case ($urandom_range(3))
          0: return WORD_MIN;
          1: return WORD_MAX;
          2: return '0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] pick_raw_count();
    int roll;
    roll = $urandom_range(99);
    if (roll < 6) return '0;
    if (roll < 12) return COUNT_W'($urandom_range(15, 9));
    if (roll < 20) return COUNT_W'(8);
    return COUNT_W'($urandom_range(4, 1));
  endfunction

  function automatic fill_mode_t pick_mode();
    int roll;
    roll = $urandom_range(9);
    if (roll < 4) return FILL_WIDE;
    if (roll < 8) return FILL_NARROW;
    if (roll == 8) return FILL_FLAT;
    return FILL_EDGE;
  endfunction

  task automatic queue_matrix(input int cells, input fill_mode_t mode);
    word_t fill;
    fill = $urandom;
    @(posedge clk);
    steady = (items_queued >= 130 && items_queued < 200);
    repeat (cells) push_word(pick_element(mode, fill));
  endtask

  task automatic settle();
    do @(negedge clk); while (items_taken != items_queued || pending_saddles.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [COUNT_W-1:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [COUNT_W-1:0] raw_rows;
    logic [COUNT_W-1:0] raw_cols;
    int cells;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // 1x1 after reset
    @(posedge clk);
    push_word(WORD_MIN);
    push_word(WORD_MAX);
    settle();

    // zero counts act as one
    write_reg(REG_ROW_COUNT, 4'd0);
    write_reg(REG_COLUMN_COUNT, 4'd0);
    @(posedge clk);
    push_word('0);
    settle();

    // write to an unused index changes nothing
    write_reg(REG_SPARE_LOW, 4'd5);
    @(posedge clk);
    push_word(-1);
    settle();

    // 2x2 with one saddle point, then 2x2 with none
    write_reg(REG_ROW_COUNT, 4'd2);
    write_reg(REG_COLUMN_COUNT, 4'd2);
    @(posedge clk);
    push_word(1);
    push_word(2);
    push_word(3);
    push_word(4);
    push_word(1);
    push_word(4);
    push_word(3);
    push_word(2);
    // partial matrix dropped by the next write
    push_word(7);
    push_word(-7);
    settle();

    // 2x3 flat matrix, every pair matches
    write_reg(REG_COLUMN_COUNT, 4'd3);
    @(posedge clk);
    repeat (6) push_word(5);
    settle();

    // oversized counts clamp to the maximum
    write_reg(REG_ROW_COUNT, 4'd15);
    write_reg(REG_COLUMN_COUNT, 4'd1);
    @(posedge clk);
    push_word(WORD_MIN);
    push_word(3);
    push_word(WORD_MAX);
    push_word(-2);
    push_word('0);
    push_word(1);
    push_word(WORD_MAX);
    push_word(4);
    settle();

    while (items_queued < WORD_TARGET) begin
      raw_rows = pick_raw_count();
      raw_cols = pick_raw_count();
      write_reg(REG_ROW_COUNT, raw_rows);
      write_reg(REG_COLUMN_COUNT, raw_cols);
      cells = used_count(raw_rows, MAX_ROWS) * used_count(raw_cols, MAX_COLUMNS);
      repeat ($urandom_range(3, 1)) queue_matrix(cells, pick_mode());
      if (cells > 1 && $urandom_range(9) == 0)
        queue_matrix($urandom_range(cells - 1, 1), FILL_WIDE);
      settle();
      if ($urandom_range(9) == 0) begin
        write_reg($urandom_range(1) ? REG_SPARE_HIGH : REG_SPARE_LOW, COUNT_W'($urandom));
      end
    end
    steady = 1'b0;

    settle();
    if (pending_saddles.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_saddles.size()));
    $display("ran %0d matrices from %0d words, %0d result words checked",
             matrices_done, items_taken, results_checked);
    $display("%0d register writes, counts from zero up to fifteen", cfg_writes);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
